### rtl/rwy_pkg.sv
// Shared types and constants for the two-class runway scheduler.
// Depends on nothing; rwy_if, rwy_stamp_queue and the top level use it by scoped names.
`default_nettype none

package rwy_pkg;

    // Fixed field widths of the result word and the configuration port.
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int SVC_W      = 12;
    localparam int MAXW_W     = 16;
    localparam int CNT_W      = 24;
    localparam int WAIT_W     = 24;
    localparam int SUM_W      = 40;
    localparam int LEVEL_W    = 7;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LAND_SERVICE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAKEOFF_SERVICE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAND_WAIT   = 2'd2;

    // Event codes of a result word.
    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_LANDED   = 2'd1,
        EV_TOOK_OFF = 2'd2,
        EV_CRASH    = 2'd3
    } event_t;

    // Per-tick commands to one stamp queue; push is applied before pop.
    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

endpackage

`default_nettype wire

### rtl/rwy_if.sv
// Valid/ready channel interfaces for the tick word and the result word.
// Depends on rwy_pkg for the field widths and the event type.
`default_nettype none

interface rwy_arrival_if;
    logic valid;
    logic ready;
    logic land_arrival;
    logic takeoff_arrival;

    modport source (output valid, output land_arrival, output takeoff_arrival, input ready);
    modport sink   (input valid, input land_arrival, input takeoff_arrival, output ready);
endinterface

interface rwy_result_if;
    logic                                valid;
    logic                                ready;
    rwy_pkg::event_t                     event_res;
    logic [rwy_pkg::WAIT_W-1:0]          wait_ticks;
    logic                                land_dropped;
    logic                                takeoff_dropped;
    logic [rwy_pkg::CNT_W-1:0]           landed_total;
    logic [rwy_pkg::CNT_W-1:0]           takeoff_total;
    logic [rwy_pkg::CNT_W-1:0]           crash_total;
    logic [rwy_pkg::SUM_W-1:0]           land_wait_sum;
    logic [rwy_pkg::SUM_W-1:0]           takeoff_wait_sum;
    logic [rwy_pkg::LEVEL_W-1:0]         land_queue_level;
    logic [rwy_pkg::LEVEL_W-1:0]         takeoff_queue_level;

    modport source (
        output valid, output event_res, output wait_ticks, output land_dropped,
        output takeoff_dropped, output landed_total, output takeoff_total,
        output crash_total, output land_wait_sum, output takeoff_wait_sum,
        output land_queue_level, output takeoff_queue_level, input ready
    );
    modport sink (
        input valid, input event_res, input wait_ticks, input land_dropped,
        input takeoff_dropped, input landed_total, input takeoff_total,
        input crash_total, input land_wait_sum, input takeoff_wait_sum,
        input land_queue_level, input takeoff_queue_level, output ready
    );
endinterface

`default_nettype wire

### rtl/rwy_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; a read of the address being written returns the old data.
`default_nettype none

module rwy_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/rwy_stamp_queue.sv
// FIFO of arrival stamps with the head stamp always on hand in the current cycle.
// Depends on rwy_pkg and rwy_ram.
`default_nettype none

module rwy_stamp_queue #(
    parameter int DEPTH     = 64,
    parameter int TIME_BITS = 24
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire rwy_pkg::queue_ctrl_t         ctrl,
    input  wire logic [TIME_BITS-1:0]         push_stamp,
    output logic      [$clog2(DEPTH+1)-1:0]   count,
    output logic                              full,
    output logic      [TIME_BITS-1:0]         head_stamp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0]        head_reg, head_next;
    logic [AW-1:0]        tail_reg, tail_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 byp_valid_reg, byp_valid_next;
    logic [TIME_BITS-1:0] byp_data_reg;
    logic [TIME_BITS-1:0] ram_rdata;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
        return r;
    endfunction

    always_comb
    begin
        head_next  = ctrl.pop  ? wrap_inc(head_reg) : head_reg;
        tail_next  = ctrl.push ? wrap_inc(tail_reg) : tail_reg;
        count_next = count_reg + CW'(ctrl.push) - CW'(ctrl.pop);
        // The RAM reads the next head while it may be written: forward the stamp.
        byp_valid_next = ctrl.push && (tail_reg == head_next);
    end

    rwy_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.push),
        .waddr (tail_reg),
        .wdata (push_stamp),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= push_stamp;
    end

    // An empty queue can only be popped in the tick that pushes into it.
    assign head_stamp = (count_reg == '0) ? push_stamp
                      : (byp_valid_reg ? byp_data_reg : ram_rdata);
    assign count      = count_reg;
    assign full       = (count_reg == CW'(DEPTH));

endmodule

`default_nettype wire

### rtl/two_class_runway_scheduler_unit.sv
// Top level of the two-class runway scheduler.
// Depends on rwy_pkg, rwy_if, rwy_stamp_queue and rwy_ram.
`default_nettype none

// Each word on the arrival channel is one tick of simulated time and carries a
// landing flag and a takeoff flag. Arrivals are stamped with the tick count and
// queued in two FIFOs of QUEUE_DEPTH entries each; an arrival that finds its
// FIFO full is lost and flagged in the result. When the server is free the
// landing head is served first: if its wait is above max_land_wait it counts as
// a crash and the server stays free, otherwise it lands and the server is busy
// for land_service_ticks further ticks. Takeoffs are served only when no landing
// waits. Every tick gives exactly one result word with the event, its wait, the
// drop flags, saturating totals and sums, and both queue levels. The block takes
// one tick word per clock while the result channel is not stalled. A tick word
// is held in the input register and its result word is then loaded into the
// result register, from which it is handed over on the result channel. The FIFO
// memories keep the head stamp on hand for the work of each tick: their registered
// read port prefetches the next head stamp each cycle, with a forwarding register
// for a stamp written the cycle before. A stalled result channel holds the
// pipeline; nothing is lost. The FIFO memories need no clearing after reset.
// Configuration is to be written through cfg_we, cfg_index and cfg_data only
// while the block is idle; the block itself does not enforce this. An index
// beyond the register list is ignored.

module two_class_runway_scheduler_unit #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TIME_BITS   = 24
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    rwy_arrival_if.sink                              arrival,
    rwy_result_if.source                             result,
    input  wire logic                                cfg_we,
    input  wire logic [rwy_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [rwy_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (TIME_BITS > rwy_pkg::MAXW_W) ? TIME_BITS : rwy_pkg::MAXW_W;
    localparam int WX_W  = (TIME_BITS > rwy_pkg::WAIT_W) ? TIME_BITS : rwy_pkg::WAIT_W;

    // Configuration registers.
    logic [rwy_pkg::SVC_W-1:0]  land_svc_reg;
    logic [rwy_pkg::SVC_W-1:0]  takeoff_svc_reg;
    logic [rwy_pkg::MAXW_W-1:0] max_wait_reg;

    // Input register holding one tick word.
    logic in_valid_reg;
    logic in_land_reg;
    logic in_takeoff_reg;

    // Scheduler state.
    logic [TIME_BITS-1:0]       tick_reg, tick_next;
    logic [rwy_pkg::SVC_W-1:0]  busy_reg, busy_next;
    logic [rwy_pkg::CNT_W-1:0]  landed_reg, landed_next;
    logic [rwy_pkg::CNT_W-1:0]  took_off_reg, took_off_next;
    logic [rwy_pkg::CNT_W-1:0]  crash_reg, crash_next;
    logic [rwy_pkg::SUM_W-1:0]  land_sum_reg, land_sum_next;
    logic [rwy_pkg::SUM_W-1:0]  takeoff_sum_reg, takeoff_sum_next;

    // Result register.
    logic                       out_valid_reg;
    rwy_pkg::event_t            event_reg, event_next;
    logic [rwy_pkg::WAIT_W-1:0] wait_reg, wait_next;
    logic                       ldrop_reg, ldrop_next;
    logic                       tdrop_reg, tdrop_next;

    // Queue interfaces.
    rwy_pkg::queue_ctrl_t       land_ctrl, takeoff_ctrl;
    logic [CW-1:0]              land_count, takeoff_count;
    logic                       land_full, takeoff_full;
    logic [TIME_BITS-1:0]       land_head, takeoff_head;

    // Work of the tick in the input register.
    logic                       proc;
    logic                       land_push, takeoff_push;
    logic                       land_avail, takeoff_avail;
    logic                       serve_land, serve_takeoff, crash;
    logic [TIME_BITS-1:0]       land_wait, takeoff_wait, served_wait;
    logic [WX_W-1:0]            wait_wide;
    logic [rwy_pkg::SUM_W:0]    land_sum_add, takeoff_sum_add;
    logic [CW+rwy_pkg::LEVEL_W-1:0] land_level_ext, takeoff_level_ext;

    // A tick is processed when the result register is free or being emptied.
    assign proc          = in_valid_reg && (!out_valid_reg || result.ready);
    assign arrival.ready = !in_valid_reg || proc;

    always_comb
    begin
        land_push     = in_land_reg && !land_full;
        takeoff_push  = in_takeoff_reg && !takeoff_full;
        ldrop_next    = in_land_reg && land_full;
        tdrop_next    = in_takeoff_reg && takeoff_full;

        // Arrivals are queued before service, so a fresh arrival can be served.
        land_avail    = (land_count != '0) || land_push;
        takeoff_avail = (takeoff_count != '0) || takeoff_push;

        serve_land    = (busy_reg == '0) && land_avail;
        serve_takeoff = (busy_reg == '0) && !land_avail && takeoff_avail;

        land_wait     = tick_reg - land_head;
        takeoff_wait  = tick_reg - takeoff_head;
        crash         = serve_land && (CMP_W'(land_wait) > CMP_W'(max_wait_reg));

        if (serve_land)
        begin
            served_wait = land_wait;
        end
        else if (serve_takeoff)
        begin
            served_wait = takeoff_wait;
        end
        else
        begin
            served_wait = '0;
        end

        // A wait too large for the result field shows as the field's maximum.
        wait_wide = WX_W'(served_wait);
        if (wait_wide > WX_W'(rwy_pkg::CNT_MAX))
        begin
            wait_next = rwy_pkg::CNT_MAX;
        end
        else
        begin
            wait_next = wait_wide[rwy_pkg::WAIT_W-1:0];
        end

        if (crash)
        begin
            event_next = rwy_pkg::EV_CRASH;
        end
        else if (serve_land)
        begin
            event_next = rwy_pkg::EV_LANDED;
        end
        else if (serve_takeoff)
        begin
            event_next = rwy_pkg::EV_TOOK_OFF;
        end
        else
        begin
            event_next = rwy_pkg::EV_NONE;
        end

        // The busy countdown stops at zero; service reloads it.
        if (busy_reg != '0)
        begin
            busy_next = busy_reg - rwy_pkg::SVC_W'(1);
        end
        else if (serve_land && !crash)
        begin
            busy_next = land_svc_reg;
        end
        else if (serve_takeoff)
        begin
            busy_next = takeoff_svc_reg;
        end
        else
        begin
            busy_next = '0;
        end

        landed_next   = landed_reg;
        took_off_next = took_off_reg;
        crash_next    = crash_reg;
        if (serve_land && !crash && (landed_reg != rwy_pkg::CNT_MAX))
        begin
            landed_next = landed_reg + rwy_pkg::CNT_W'(1);
        end
        if (crash && (crash_reg != rwy_pkg::CNT_MAX))
        begin
            crash_next = crash_reg + rwy_pkg::CNT_W'(1);
        end
        if (serve_takeoff && (took_off_reg != rwy_pkg::CNT_MAX))
        begin
            took_off_next = took_off_reg + rwy_pkg::CNT_W'(1);
        end

        // Crashes are part of the landing wait sum as well.
        land_sum_add    = {1'b0, land_sum_reg} + (rwy_pkg::SUM_W+1)'(land_wait);
        takeoff_sum_add = {1'b0, takeoff_sum_reg} + (rwy_pkg::SUM_W+1)'(takeoff_wait);
        land_sum_next    = land_sum_reg;
        takeoff_sum_next = takeoff_sum_reg;
        if (serve_land)
        begin
            land_sum_next = (land_sum_add >= {1'b0, rwy_pkg::SUM_MAX})
                          ? rwy_pkg::SUM_MAX : land_sum_add[rwy_pkg::SUM_W-1:0];
        end
        if (serve_takeoff)
        begin
            takeoff_sum_next = (takeoff_sum_add >= {1'b0, rwy_pkg::SUM_MAX})
                             ? rwy_pkg::SUM_MAX : takeoff_sum_add[rwy_pkg::SUM_W-1:0];
        end

        tick_next = tick_reg + TIME_BITS'(1);

        land_ctrl.push    = proc && land_push;
        land_ctrl.pop     = proc && serve_land;
        takeoff_ctrl.push = proc && takeoff_push;
        takeoff_ctrl.pop  = proc && serve_takeoff;
    end

    rwy_stamp_queue #(
        .DEPTH     (QUEUE_DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_land_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (land_ctrl),
        .push_stamp (tick_reg),
        .count      (land_count),
        .full       (land_full),
        .head_stamp (land_head)
    );

    rwy_stamp_queue #(
        .DEPTH     (QUEUE_DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_takeoff_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (takeoff_ctrl),
        .push_stamp (tick_reg),
        .count      (takeoff_count),
        .full       (takeoff_full),
        .head_stamp (takeoff_head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            land_svc_reg    <= rwy_pkg::SVC_W'(4);
            takeoff_svc_reg <= rwy_pkg::SVC_W'(2);
            max_wait_reg    <= rwy_pkg::MAXW_W'(20);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rwy_pkg::CFG_LAND_SERVICE:    land_svc_reg    <= cfg_data[rwy_pkg::SVC_W-1:0];
                rwy_pkg::CFG_TAKEOFF_SERVICE: takeoff_svc_reg <= cfg_data[rwy_pkg::SVC_W-1:0];
                rwy_pkg::CFG_MAX_LAND_WAIT:   max_wait_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            tick_reg        <= '0;
            busy_reg        <= '0;
            landed_reg      <= '0;
            took_off_reg    <= '0;
            crash_reg       <= '0;
            land_sum_reg    <= '0;
            takeoff_sum_reg <= '0;
        end
        else
        begin
            if (arrival.valid && arrival.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                in_valid_reg <= 1'b0;
            end

            if (proc)
            begin
                out_valid_reg   <= 1'b1;
                tick_reg        <= tick_next;
                busy_reg        <= busy_next;
                landed_reg      <= landed_next;
                took_off_reg    <= took_off_next;
                crash_reg       <= crash_next;
                land_sum_reg    <= land_sum_next;
                takeoff_sum_reg <= takeoff_sum_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (arrival.valid && arrival.ready)
        begin
            in_land_reg    <= arrival.land_arrival;
            in_takeoff_reg <= arrival.takeoff_arrival;
        end
        if (proc)
        begin
            event_reg <= event_next;
            wait_reg  <= wait_next;
            ldrop_reg <= ldrop_next;
            tdrop_reg <= tdrop_next;
        end
    end

    // Totals, sums and levels change only when a result is loaded, so the
    // state registers feed the result word directly.
    assign land_level_ext    = {{rwy_pkg::LEVEL_W{1'b0}}, land_count};
    assign takeoff_level_ext = {{rwy_pkg::LEVEL_W{1'b0}}, takeoff_count};

    assign result.valid               = out_valid_reg;
    assign result.event_res           = event_reg;
    assign result.wait_ticks          = wait_reg;
    assign result.land_dropped        = ldrop_reg;
    assign result.takeoff_dropped     = tdrop_reg;
    assign result.landed_total        = landed_reg;
    assign result.takeoff_total       = took_off_reg;
    assign result.crash_total         = crash_reg;
    assign result.land_wait_sum       = land_sum_reg;
    assign result.takeoff_wait_sum    = takeoff_sum_reg;
    assign result.land_queue_level    = land_level_ext[rwy_pkg::LEVEL_W-1:0];
    assign result.takeoff_queue_level = takeoff_level_ext[rwy_pkg::LEVEL_W-1:0];

endmodule

`default_nettype wire
